// ===== rtl/core/dcp_pkg.sv =====
// Shared types, codes and reset constants for the download chunk pacer.
package dcp_pkg;

  localparam int unsigned P_MAX_BYTES = 32'd16777216;

  localparam int CMD_W   = 2;
  localparam int NOW_W   = 32;
  localparam int BYTES_W = 12;
  localparam int PCT_W   = 7;
  localparam int MS_W    = 16;
  localparam int CAUSE_W = 3;
  localparam int STAT_W  = 2;
  localparam int CAP_W   = 21;
  localparam int YIELD_W = 8;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;
  localparam int MS_PER_S = 1000;

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CHUNK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POLL  = 2'd2;

  localparam logic [CAUSE_W-1:0] CAUSE_NONE     = 3'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_RATE     = 3'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_CRITICAL = 3'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_LOW      = 3'd3;
  localparam logic [CAUSE_W-1:0] CAUSE_YIELD    = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_STALLED   = 2'd2;

  localparam logic [IDX_W-1:0] REG_RATE_CAP     = 3'd0;
  localparam logic [IDX_W-1:0] REG_SLEEP_MAX    = 3'd1;
  localparam logic [IDX_W-1:0] REG_FILL_CRIT    = 3'd2;
  localparam logic [IDX_W-1:0] REG_FILL_LOW     = 3'd3;
  localparam logic [IDX_W-1:0] REG_BACKOFF_CRIT = 3'd4;
  localparam logic [IDX_W-1:0] REG_BACKOFF_LOW  = 3'd5;
  localparam logic [IDX_W-1:0] REG_YIELD_EVERY  = 3'd6;
  localparam logic [IDX_W-1:0] REG_STALL_TO     = 3'd7;

  localparam logic [CAP_W-1:0]   RST_RATE_CAP     = 21'd6144;
  localparam logic [MS_W-1:0]    RST_SLEEP_MAX    = 16'd400;
  localparam logic [PCT_W-1:0]   RST_FILL_CRIT    = 7'd8;
  localparam logic [PCT_W-1:0]   RST_FILL_LOW     = 7'd50;
  localparam logic [MS_W-1:0]    RST_BACKOFF_CRIT = 16'd20;
  localparam logic [MS_W-1:0]    RST_BACKOFF_LOW  = 16'd5;
  localparam logic [YIELD_W-1:0] RST_YIELD_EVERY  = 8'd8;
  localparam logic [NOW_W-1:0]   RST_STALL_TO     = 32'd20000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_CMP,
    ST_DIV,
    ST_FIN,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic mul;
    logic cmp;
    logic div_start;
    logic fin;
    logic write_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rate_path;
    logic need_div;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/download_chunk_pacer.sv =====
// Top level of the download chunk pacer.
// One request at a time. A start, idle poll, or chunk without live audio is first
// evaluated; its result is then loaded into the output register once that is free.
// A live-audio chunk also runs a multiply and a compare; when the window is within
// the cap, the result is loaded after the compare. When the rate cap is exceeded, a
// restoring divide of bytes*1000 by the cap follows at one quotient bit per cycle,
// giving TW+10 quotient bits, where TW = clog2(MAX_BYTES+1); a finish step then
// clamps the delay to the sleep maximum before the load. The next request is taken
// once the result sits in the output register, even if the consumer has not yet
// taken it.
module download_chunk_pacer import dcp_pkg::*; #(
  parameter int unsigned MAX_BYTES = P_MAX_BYTES,
  localparam int TW = $clog2(MAX_BYTES + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   command,
  input  logic [NOW_W-1:0]   now_ms,
  input  logic [BYTES_W-1:0] chunk_bytes,
  input  logic               live_audio,
  input  logic               fill_known,
  input  logic [PCT_W-1:0]   fill_pct,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [MS_W-1:0]    delay_ms,
  output logic [CAUSE_W-1:0] delay_cause,
  output logic [STAT_W-1:0]  status,
  output logic [TW-1:0]      total_bytes
);

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  dcp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dcp_datapath #(
    .MAX_BYTES (MAX_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .command     (command),
    .now_ms      (now_ms),
    .chunk_bytes (chunk_bytes),
    .live_audio  (live_audio),
    .fill_known  (fill_known),
    .fill_pct    (fill_pct),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .delay_ms    (delay_ms),
    .delay_cause (delay_cause),
    .status      (status),
    .total_bytes (total_bytes)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in flight");

  a_no_cause_no_delay: assert property (@(posedge clk) disable iff (rst)
    out_valid && delay_cause == CAUSE_NONE |-> delay_ms == '0)
    else $error("delay without cause");

  a_yield_one_ms: assert property (@(posedge clk) disable iff (rst)
    out_valid && delay_cause == CAUSE_YIELD |-> delay_ms == MS_W'(1))
    else $error("routine yield not 1 ms");

  a_fail_no_delay: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_OK |-> delay_ms == '0 && delay_cause == CAUSE_NONE)
    else $error("delay reported with failure status");

endmodule

// ===== rtl/core/dcp_div.sv =====
// Restoring divider, one quotient bit per cycle.
module dcp_div import dcp_pkg::*; #(
  parameter int DW = 35,
  parameter int VW = 21
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          running;
  logic [CW-1:0] count;
  logic [VW-1:0] rem;
  logic [DW-1:0] quo;
  logic [VW:0]   shifted;
  logic          fits;

  assign shifted  = {rem, quo[DW-1]};
  assign fits     = shifted >= {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
      count   <= CW'(DW);
    end else if (running) begin
      count <= count - 1'b1;
      if (count == CW'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (running) begin
      if (fits) begin
        rem <= VW'(shifted - {1'b0, divisor});
      end else begin
        rem <= shifted[VW-1:0];
      end
      quo <= {quo[DW-2:0], fits};
    end
  end

endmodule

// ===== rtl/core/dcp_datapath.sv =====
// Pacer datapath: input capture, config, transfer state, rate-cap math, result register.
module dcp_datapath import dcp_pkg::*; #(
  parameter int unsigned MAX_BYTES = P_MAX_BYTES,
  localparam int TW = $clog2(MAX_BYTES + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         stat,
  input  logic               cfg_write,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic [CMD_W-1:0]   command,
  input  logic [NOW_W-1:0]   now_ms,
  input  logic [BYTES_W-1:0] chunk_bytes,
  input  logic               live_audio,
  input  logic               fill_known,
  input  logic [PCT_W-1:0]   fill_pct,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [MS_W-1:0]    delay_ms,
  output logic [CAUSE_W-1:0] delay_cause,
  output logic [STAT_W-1:0]  status,
  output logic [TW-1:0]      total_bytes
);

  localparam int SW = ((TW > BYTES_W) ? TW : BYTES_W) + 1;
  localparam int DW = TW + 10;
  localparam int PW = CAP_W + NOW_W;
  localparam int CW = (DW > PW) ? DW : PW;
  localparam int XW = (DW > NOW_W) ? DW : NOW_W;

  // configuration
  logic [CAP_W-1:0]   rate_cap;
  logic [MS_W-1:0]    sleep_max;
  logic [PCT_W-1:0]   fill_crit;
  logic [PCT_W-1:0]   fill_low;
  logic [MS_W-1:0]    backoff_crit;
  logic [MS_W-1:0]    backoff_low;
  logic [YIELD_W-1:0] yield_every;
  logic [NOW_W-1:0]   stall_to;

  // captured request
  logic [CMD_W-1:0]   cmd_q;
  logic [NOW_W-1:0]   now_q;
  logic [BYTES_W-1:0] bytes_q;
  logic               live_q;
  logic               known_q;
  logic [PCT_W-1:0]   fill_q;

  // transfer state
  logic [TW-1:0]      byte_total, byte_total_next;
  logic [NOW_W-1:0]   last_data, last_data_next;
  logic [NOW_W-1:0]   window_start, window_start_next;
  logic [TW-1:0]      window_base, window_base_next;
  logic               window_active, window_active_next;
  logic [PCT_W-1:0]   prev_fill, prev_fill_next;
  logic               prev_fill_valid, prev_fill_valid_next;
  logic [YIELD_W-1:0] yield_count, yield_count_next;
  logic [STAT_W-1:0]  fail_latch, fail_latch_next;

  // result and rate math
  logic [MS_W-1:0]    res_delay, res_delay_next;
  logic [CAUSE_W-1:0] res_cause, res_cause_next;
  logic               rate_path;
  logic [NOW_W-1:0]   elapsed, elapsed_next;
  logic [TW-1:0]      sent, sent_next;
  logic [PW-1:0]      allowed;
  logic [DW-1:0]      sent_ms;
  logic               div_done;
  logic [DW-1:0]      quot;
  logic [XW-1:0]      need;

  logic [SW-1:0]      sum;
  logic [YIELD_W-1:0] yield_inc;
  logic               draining;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_cap     <= RST_RATE_CAP;
      sleep_max    <= RST_SLEEP_MAX;
      fill_crit    <= RST_FILL_CRIT;
      fill_low     <= RST_FILL_LOW;
      backoff_crit <= RST_BACKOFF_CRIT;
      backoff_low  <= RST_BACKOFF_LOW;
      yield_every  <= RST_YIELD_EVERY;
      stall_to     <= RST_STALL_TO;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RATE_CAP:     rate_cap     <= cfg_data[CAP_W-1:0];
        REG_SLEEP_MAX:    sleep_max    <= cfg_data[MS_W-1:0];
        REG_FILL_CRIT:    fill_crit    <= cfg_data[PCT_W-1:0];
        REG_FILL_LOW:     fill_low     <= cfg_data[PCT_W-1:0];
        REG_BACKOFF_CRIT: backoff_crit <= cfg_data[MS_W-1:0];
        REG_BACKOFF_LOW:  backoff_low  <= cfg_data[MS_W-1:0];
        REG_YIELD_EVERY:  yield_every  <= cfg_data[YIELD_W-1:0];
        REG_STALL_TO:     stall_to     <= cfg_data[NOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_q   <= command;
      now_q   <= now_ms;
      bytes_q <= chunk_bytes;
      live_q  <= live_audio;
      known_q <= fill_known;
      fill_q  <= fill_pct;
    end
  end

  assign sum       = SW'(byte_total) + SW'(bytes_q);
  assign yield_inc = yield_count + 1'b1;
  assign draining  = prev_fill_valid && (fill_q < prev_fill);

  always_comb begin
    byte_total_next      = byte_total;
    last_data_next       = last_data;
    window_start_next    = window_start;
    window_base_next     = window_base;
    window_active_next   = window_active;
    prev_fill_next       = prev_fill;
    prev_fill_valid_next = prev_fill_valid;
    yield_count_next     = yield_count;
    fail_latch_next      = fail_latch;
    res_delay_next       = '0;
    res_cause_next       = CAUSE_NONE;
    rate_path            = 1'b0;
    elapsed_next         = elapsed;
    sent_next            = sent;
    priority if (cmd_q == CMD_START) begin
      byte_total_next      = '0;
      last_data_next       = now_q;
      window_start_next    = '0;
      window_base_next     = '0;
      window_active_next   = 1'b0;
      prev_fill_next       = '0;
      prev_fill_valid_next = 1'b0;
      yield_count_next     = '0;
      fail_latch_next      = STAT_OK;
    end else if (fail_latch != STAT_OK) begin
      // hold: latched failure freezes the transfer
    end else if (cmd_q == CMD_POLL) begin
      if ((now_q - last_data) > stall_to) begin
        fail_latch_next = STAT_STALLED;
      end
    end else if (cmd_q == CMD_CHUNK && bytes_q != '0) begin
      if (sum > SW'(MAX_BYTES)) begin
        fail_latch_next = STAT_TOO_LARGE;
      end else begin
        byte_total_next = sum[TW-1:0];
        last_data_next  = now_q;
        if (live_q) begin
          if (!window_active) begin
            window_active_next = 1'b1;
            window_start_next  = now_q;
            window_base_next   = sum[TW-1:0];
          end
          yield_count_next = '0;
          rate_path        = 1'b1;
          elapsed_next     = now_q - window_start_next;
          sent_next        = sum[TW-1:0] - window_base_next;
        end else begin
          window_active_next = 1'b0;
          if (known_q) begin
            if (fill_q < fill_crit) begin
              res_delay_next = backoff_crit;
              res_cause_next = CAUSE_CRITICAL;
            end else if (fill_q < fill_low && draining) begin
              res_delay_next = backoff_low;
              res_cause_next = CAUSE_LOW;
            end
            prev_fill_next       = fill_q;
            prev_fill_valid_next = 1'b1;
          end
          // zero backoff counts as none: fall through to routine yield
          if (res_delay_next != '0) begin
            yield_count_next = '0;
          end else begin
            res_cause_next   = CAUSE_NONE;
            yield_count_next = yield_inc;
            if (yield_inc >= yield_every) begin
              yield_count_next = '0;
              res_delay_next   = MS_W'(1);
              res_cause_next   = CAUSE_YIELD;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_total      <= '0;
      last_data       <= '0;
      window_start    <= '0;
      window_base     <= '0;
      window_active   <= 1'b0;
      prev_fill       <= '0;
      prev_fill_valid <= 1'b0;
      yield_count     <= '0;
      fail_latch      <= STAT_OK;
    end else if (cmd.eval) begin
      byte_total      <= byte_total_next;
      last_data       <= last_data_next;
      window_start    <= window_start_next;
      window_base     <= window_base_next;
      window_active   <= window_active_next;
      prev_fill       <= prev_fill_next;
      prev_fill_valid <= prev_fill_valid_next;
      yield_count     <= yield_count_next;
      fail_latch      <= fail_latch_next;
    end
  end

  assign need = XW'(quot) - XW'(elapsed);

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      res_delay <= res_delay_next;
      res_cause <= res_cause_next;
      elapsed   <= elapsed_next;
      sent      <= sent_next;
    end else if (cmd.mul) begin
      allowed <= PW'(rate_cap) * PW'(elapsed);
      sent_ms <= DW'(sent) * DW'(MS_PER_S);
    end else if (cmd.cmp) begin
      // zero cap: any bytes in the window wait the full clamp
      if (rate_cap == '0 && sent != '0) begin
        res_delay <= sleep_max;
        res_cause <= (sleep_max != '0) ? CAUSE_RATE : CAUSE_NONE;
      end else begin
        res_delay <= '0;
        res_cause <= CAUSE_NONE;
      end
    end else if (cmd.fin) begin
      if (need > XW'(sleep_max)) begin
        res_delay <= sleep_max;
        res_cause <= (sleep_max != '0) ? CAUSE_RATE : CAUSE_NONE;
      end else begin
        res_delay <= need[MS_W-1:0];
        res_cause <= (need != '0) ? CAUSE_RATE : CAUSE_NONE;
      end
    end
  end

  dcp_div #(
    .DW (DW),
    .VW (CAP_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sent_ms),
    .divisor  (rate_cap),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_out) begin
      delay_ms    <= res_delay;
      delay_cause <= res_cause;
      status      <= fail_latch;
      total_bytes <= byte_total;
    end
  end

  assign stat.rate_path = rate_path;
  assign stat.need_div  = (rate_cap != '0) && (CW'(sent_ms) > CW'(allowed));
  assign stat.div_done  = div_done;
  assign stat.out_free  = !out_valid || out_ready;

endmodule

// ===== rtl/core/dcp_ctrl.sv =====
// Pacer controller: sequences capture, evaluation, rate-cap divide and result hand-off.
module dcp_ctrl import dcp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t stat,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_EVAL;
      ST_EVAL:  state_next = stat.rate_path ? ST_MUL : ST_WRITE;
      ST_MUL:   state_next = ST_CMP;
      ST_CMP:   state_next = stat.need_div ? ST_DIV : ST_WRITE;
      ST_DIV:   if (stat.div_done) state_next = ST_FIN;
      ST_FIN:   state_next = ST_WRITE;
      ST_WRITE: if (stat.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_EVAL:  cmd.eval      = 1'b1;
      ST_MUL:   cmd.mul       = 1'b1;
      ST_CMP: begin
        cmd.cmp       = 1'b1;
        cmd.div_start = stat.need_div;
      end
      ST_DIV:   ;
      ST_FIN:   cmd.fin       = 1'b1;
      ST_WRITE: cmd.write_out = stat.out_free;
      default:  ;
    endcase
  end

endmodule
